@@ rtl/fscm_pkg.sv @@
// Shared constants and types of the frustum sphere cull mask block.
package fscm_pkg;

  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned MASK_BITS  = 16;
  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned IDX_BITS   = 3;
  localparam int unsigned Q_SHIFT    = 16;

  // Width of one signed product of two coordinates.
  localparam int unsigned PROD_W = 2 * COORD_BITS;
  // Plane distance: three products plus (d + r) scaled by one in Q16.16.
  localparam int unsigned PSUM_W = 2 * COORD_BITS + 3;
  // Differences and radius sums carry one extra bit.
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  // Square of a difference, and the sum of three squares.
  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam int unsigned DIST_W = SQ_W + 2;

  localparam logic [IDX_BITS-1:0] SPHERE_IDX = IDX_BITS'(NUM_PLANES);

  // Request kinds on the opcode bit of tuser.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_e;

  // Register index, taken from the word address, and its byte address.
  localparam logic       REG_VIEW_MASK  = 1'b0;
  localparam logic [2:0] VIEW_MASK_ADDR = {REG_VIEW_MASK, 2'b00};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [MASK_BITS-1:0] mask_t;

  // One test request as it travels down the row of cells.
  typedef struct packed {
    logic   valid;
    logic   bypass;
    logic   culled;
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t r;
    mask_t  mask;
  } item_t;

  // Write of one table entry into the cell that owns it.
  typedef struct packed {
    logic   en;
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
  } entry_wr_t;

endpackage

@@ rtl/frustum_sphere_cull_mask.sv @@
// Top level of the frustum sphere cull mask block.
//
// Requests arrive on the s_axis channel. A load request (opcode 0) writes one
// table entry: entries 0 to 5 are frustum planes (a, b, c, d) and entry 6 is
// the frustum bounding sphere (centre x, y, z, radius); indexes above that are
// dropped. A load gives no result, and loads are taken back to back while no
// test is in the row. A test request (opcode 1) carries an object sphere and
// its old mask and gives one result on the m_axis channel.
//
// A test travels down a row of cells, one cell per table entry. The sphere cell
// has difference, square and compare stages, and each plane cell has products
// and sum-and-sign stages. The next request is taken only once the result of
// the test in the row has been written to the output register.
// If the receiver stalls, the result waits in the output register while the
// next request is still accepted; a second result that reaches the end of the
// row waits there, holding the row, until the output register is free.
// The view culling mask is written through the APB port at address 0. Reset
// empties the row and the output register, clears the view mask, and leaves the
// table entries without a value until they are loaded.
module frustum_sphere_cull_mask import fscm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Fields from bit 0 up: coef_a, coef_b, coef_c, coef_d, old_mask.
  input  logic [143:0] s_axis_tdata,
  // Fields from bit 0 up: opcode, entry_index.
  input  logic [3:0]   s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0 up: new_mask.
  output logic [15:0]  m_axis_tdata,
  // Fields from bit 0 up: visible.
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  op_e                 in_op;
  logic [IDX_BITS-1:0] in_idx;
  coord_t              in_a, in_b, in_c, in_d;
  mask_t               in_mask;
  logic                in_hs, load_req;

  item_t     head_item;
  item_t     chain [NUM_PLANES+1];
  entry_wr_t sphere_wr;
  entry_wr_t plane_wr [NUM_PLANES];
  item_t     last;
  logic      adv;

  mask_t view_mask_q;
  logic  busy_q;
  logic  out_valid_q;
  logic  visible_q;
  mask_t new_mask_q;
  mask_t new_mask_d;

  // Request decode.
  assign in_op   = op_e'(s_axis_tuser[0]);
  assign in_idx  = s_axis_tuser[3:1];
  assign in_a    = s_axis_tdata[31:0];
  assign in_b    = s_axis_tdata[63:32];
  assign in_c    = s_axis_tdata[95:64];
  assign in_d    = s_axis_tdata[127:96];
  assign in_mask = s_axis_tdata[143:128];

  // Only one test is in the row at a time.
  assign s_axis_tready = !busy_q;
  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign load_req      = in_hs && (in_op == OP_LOAD);

  always_comb begin
    head_item        = '0;
    head_item.valid  = in_hs && (in_op == OP_TEST);
    // A negative object radius skips every test.
    head_item.bypass = in_d[COORD_BITS-1];
    head_item.culled = 1'b0;
    head_item.x      = in_a;
    head_item.y      = in_b;
    head_item.z      = in_c;
    head_item.r      = in_d;
    head_item.mask   = in_mask;
  end

  always_comb begin
    sphere_wr.en = load_req && (in_idx == SPHERE_IDX);
    sphere_wr.a  = in_a;
    sphere_wr.b  = in_b;
    sphere_wr.c  = in_c;
    sphere_wr.d  = in_d;
    for (int p = 0; p < NUM_PLANES; p++) begin
      plane_wr[p].en = load_req && (in_idx == IDX_BITS'(p));
      plane_wr[p].a  = in_a;
      plane_wr[p].b  = in_b;
      plane_wr[p].c  = in_c;
      plane_wr[p].d  = in_d;
    end
  end

  // The whole row holds while a finished test waits for the output register.
  assign last = chain[NUM_PLANES];
  assign adv  = !(last.valid && out_valid_q && !m_axis_tready);

  fscm_sphere_cell u_sphere (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .wr_i   (sphere_wr),
    .item_i (head_item),
    .item_o (chain[0])
  );

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
    fscm_plane_cell u_plane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .wr_i   (plane_wr[g]),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  always_comb begin
    if (last.bypass) begin
      new_mask_d = '0;
    end else if (last.culled) begin
      new_mask_d = last.mask | view_mask_q;
    end else begin
      new_mask_d = last.mask & ~view_mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (head_item.valid) begin
        busy_q <= 1'b1;
      end else if (last.valid && adv) begin
        busy_q <= 1'b0;
      end
      if (last.valid && adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.valid && adv) begin
      visible_q  <= last.bypass || !last.culled;
      new_mask_q <= new_mask_d;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = new_mask_q;
  assign m_axis_tuser[0] = visible_q;

  // Configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_mask_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_VIEW_MASK)) begin
      view_mask_q <= pwdata[MASK_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VIEW_MASK) ? 32'(view_mask_q) : '0;

`ifndef ASSERT_OFF
  // A culled result carries every view mask bit.
  a_culled_sets_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> ((m_axis_tdata & view_mask_q) == view_mask_q))
    else $error("culled result lacks view mask bits");

  // A visible result carries none of them.
  a_visible_clears_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> ((m_axis_tdata & view_mask_q) == '0))
    else $error("visible result keeps view mask bits");

  // The row only goes idle by handing its test to the output register.
  a_busy_ends_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> out_valid_q)
    else $error("test left the row without a result");

  // A test at the end of the row always has the busy flag set, so no test request is taken while it is in the row.
  a_single_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.valid |-> busy_q)
    else $error("test in the row without busy flag");
`endif

endmodule

@@ rtl/fscm_sphere_cell.sv @@
// Head cell of the row: holds the frustum bounding sphere and tests the object distance.
module fscm_sphere_cell import fscm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  entry_wr_t wr_i,
  input  item_t     item_i,
  output item_t     item_o
);

  coord_t fx_q, fy_q, fz_q, fr_q;

  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q, rs_q;
  logic signed [DIFF_W-1:0] dx_d, dy_d, dz_d, rs_d;
  logic signed [SQ_W-1:0]   dx_ext, dy_ext, dz_ext, rs_ext;
  logic signed [SQ_W-1:0]   dx2_q, dy2_q, dz2_q, rs2_q;
  logic signed [DIST_W-1:0] dist_d, rs2_ext;

  item_t s1_q, s2_q, s3_q, s3_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      fx_q <= wr_i.a;
      fy_q <= wr_i.b;
      fz_q <= wr_i.c;
      fr_q <= wr_i.d;
    end
  end

  always_comb begin
    dx_d = DIFF_W'($signed(item_i.x)) - DIFF_W'(fx_q);
    dy_d = DIFF_W'($signed(item_i.y)) - DIFF_W'(fy_q);
    dz_d = DIFF_W'($signed(item_i.z)) - DIFF_W'(fz_q);
    rs_d = DIFF_W'($signed(item_i.r)) + DIFF_W'(fr_q);
    dx_ext = SQ_W'(dx_q);
    dy_ext = SQ_W'(dy_q);
    dz_ext = SQ_W'(dz_q);
    rs_ext = SQ_W'(rs_q);
    dist_d  = DIST_W'(dx2_q) + DIST_W'(dy2_q) + DIST_W'(dz2_q);
    rs2_ext = DIST_W'(rs2_q);
    s3_d = s2_q;
    s3_d.culled = s2_q.culled | (rs2_ext < dist_d);
  end

  // Payload stages: differences, then squares.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      dz_q  <= dz_d;
      rs_q  <= rs_d;
      dx2_q <= dx_ext * dx_ext;
      dy2_q <= dy_ext * dy_ext;
      dz2_q <= dz_ext * dz_ext;
      rs2_q <= rs_ext * rs_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (adv_i) begin
      s1_q <= item_i;
      s2_q <= s1_q;
      s3_q <= s3_d;
    end
  end

  assign item_o = s3_q;

endmodule

@@ rtl/fscm_plane_cell.sv @@
// One plane cell of the row: holds a frustum plane and tests the sphere against it.
module fscm_plane_cell import fscm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  entry_wr_t wr_i,
  input  item_t     item_i,
  output item_t     item_o
);

  coord_t a_q, b_q, c_q, d_q;

  logic signed [PROD_W-1:0] a_ext, b_ext, c_ext, x_ext, y_ext, z_ext;
  logic signed [PROD_W-1:0] pa_q, pb_q, pc_q;
  logic signed [DIFF_W-1:0] dr;
  logic signed [PSUM_W-1:0] sum_d;

  item_t s1_q, s2_q, s2_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      a_q <= wr_i.a;
      b_q <= wr_i.b;
      c_q <= wr_i.c;
      d_q <= wr_i.d;
    end
  end

  always_comb begin
    a_ext = PROD_W'(a_q);
    b_ext = PROD_W'(b_q);
    c_ext = PROD_W'(c_q);
    x_ext = PROD_W'($signed(item_i.x));
    y_ext = PROD_W'($signed(item_i.y));
    z_ext = PROD_W'($signed(item_i.z));
    // The plane offset and the object radius both scale by one in Q16.16.
    dr    = DIFF_W'(d_q) + DIFF_W'($signed(s1_q.r));
    sum_d = PSUM_W'(pa_q) + PSUM_W'(pb_q) + PSUM_W'(pc_q) + (PSUM_W'(dr) <<< Q_SHIFT);
    s2_d = s1_q;
    s2_d.culled = s1_q.culled | sum_d[PSUM_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pa_q <= a_ext * x_ext;
      pb_q <= b_ext * y_ext;
      pc_q <= c_ext * z_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (adv_i) begin
      s1_q <= item_i;
      s2_q <= s2_d;
    end
  end

  assign item_o = s2_q;

endmodule
